### rtl/core/ils_pkg.sv
`timescale 1ns / 1ps
// ils_pkg: shared types and constants for the indexed list store
// used by ils_cell, indexed_list_store_top and ils_checker
package ils_pkg;

  localparam int CAPACITY  = 16;
  localparam int ELEM_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KIND_W    = 3;
  localparam int POS_W     = 5;
  localparam int STAT_W    = 2;
  localparam int FOUND_W   = 4;

  localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SET    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_POP    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FIND   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [POS_W-1:0]     position;
    logic [ELEM_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [ELEM_BITS-1:0] value_out;
    logic [FOUND_W-1:0]   found_position;
    logic [CNT_W-1:0]     length;
    logic                 empty_res;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_APPEND,
    OP_INSERT,
    OP_SET,
    OP_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic                 cmp;
    logic [IDX_W-1:0]     pos;
    logic [CNT_W-1:0]     count;
    logic [ELEM_BITS-1:0] value;
  } cell_cmd_t;

endpackage

### rtl/core/ils_cell.sv
`timescale 1ns / 1ps
// ils_cell: one list slot; loads, shifts from a neighbour or compares
// depends on ils_pkg
module ils_cell (
  input  logic                          clk,
  input  logic [ils_pkg::IDX_W-1:0]     idx,
  input  ils_pkg::cell_cmd_t            cmd,
  input  logic [ils_pkg::ELEM_BITS-1:0] lo_data,
  input  logic [ils_pkg::ELEM_BITS-1:0] hi_data,
  output logic [ils_pkg::ELEM_BITS-1:0] data,
  output logic                          match
);

  logic [ils_pkg::CNT_W-1:0] idx_c;
  logic [ils_pkg::CNT_W-1:0] idx_c1;

  assign idx_c  = ils_pkg::CNT_W'(idx);
  assign idx_c1 = idx_c + ils_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ils_pkg::OP_APPEND: begin
        if (idx_c == cmd.count) data <= cmd.value;
      end
      ils_pkg::OP_INSERT: begin
        if (idx == cmd.pos) data <= cmd.value;
        else if (idx > cmd.pos && idx_c <= cmd.count) data <= lo_data;
      end
      ils_pkg::OP_SET: begin
        if (idx == cmd.pos) data <= cmd.value;
      end
      ils_pkg::OP_REMOVE: begin
        if (idx >= cmd.pos && idx_c1 < cmd.count) data <= hi_data;
      end
      default: begin
      end
    endcase
    // compare result held until the next find
    if (cmd.cmp) match <= (idx_c < cmd.count) && (data == cmd.value);
  end

endmodule

### rtl/core/indexed_list_store_top.sv
`timescale 1ns / 1ps
// indexed_list_store_top: ordered list held in a row of shifting cells
// sequence: the request is captured, S_EXEC updates the cells, S_FIN registers the response
// requests: one transaction at a time, through the capture, cell update and find encode
// steps; the next request also waits while an earlier response is still stalled
// reset: synchronous rst empties the list; slot contents stay undefined until written
// depends on ils_pkg and ils_cell
module indexed_list_store_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ils_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ils_pkg::rsp_t rsp
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FIN} state_t;

  localparam logic [ils_pkg::CNT_W-1:0] CAP_CNT = ils_pkg::CNT_W'(ils_pkg::CAPACITY);

  state_t                        state;
  ils_pkg::req_t                 req_r;
  logic [ils_pkg::CNT_W-1:0]     count;
  logic [ils_pkg::CNT_W-1:0]     count_next;
  logic [ils_pkg::STAT_W-1:0]    status_r;
  logic [ils_pkg::STAT_W-1:0]    status_next;
  logic [ils_pkg::ELEM_BITS-1:0] rd_r;
  logic [ils_pkg::ELEM_BITS-1:0] rd_next;
  logic                          find_r;
  ils_pkg::cell_cmd_t            cmd;
  ils_pkg::cell_op_t             op_next;
  logic                          cmp_next;
  logic [ils_pkg::ELEM_BITS-1:0] cell_data [ils_pkg::CAPACITY];
  logic [ils_pkg::CAPACITY-1:0]  match;
  logic [ils_pkg::FOUND_W-1:0]   found;
  logic [ils_pkg::IDX_W-1:0]     pos_idx;

  assign pos_idx = req_r.position[ils_pkg::IDX_W-1:0];

  always_comb begin
    status_next = ils_pkg::ST_OK;
    count_next  = count;
    rd_next     = '0;
    op_next     = ils_pkg::OP_HOLD;
    cmp_next    = 1'b0;
    unique case (req_r.kind) inside
      ils_pkg::KIND_APPEND: begin
        if (count >= CAP_CNT) status_next = ils_pkg::ST_FULL;
        else begin
          op_next    = ils_pkg::OP_APPEND;
          count_next = count + ils_pkg::CNT_W'(1);
        end
      end
      ils_pkg::KIND_INSERT: begin
        if (req_r.position > count) status_next = ils_pkg::ST_BAD_POS;
        else if (count >= CAP_CNT) status_next = ils_pkg::ST_FULL;
        else begin
          op_next    = ils_pkg::OP_INSERT;
          count_next = count + ils_pkg::CNT_W'(1);
        end
      end
      ils_pkg::KIND_GET, ils_pkg::KIND_SET, ils_pkg::KIND_REMOVE, ils_pkg::KIND_POP: begin
        if (req_r.position >= count) status_next = ils_pkg::ST_BAD_POS;
        else if (req_r.kind == ils_pkg::KIND_GET) rd_next = cell_data[pos_idx];
        else if (req_r.kind == ils_pkg::KIND_SET) op_next = ils_pkg::OP_SET;
        else begin
          if (req_r.kind == ils_pkg::KIND_POP) rd_next = cell_data[pos_idx];
          op_next    = ils_pkg::OP_REMOVE;
          count_next = count - ils_pkg::CNT_W'(1);
        end
      end
      ils_pkg::KIND_FIND: begin
        cmp_next = 1'b1;
      end
      default: begin
        count_next = '0;
      end
    endcase
  end

  always_comb begin
    cmd.op    = (state == S_EXEC) ? op_next : ils_pkg::OP_HOLD;
    cmd.cmp   = (state == S_EXEC) && cmp_next;
    cmd.pos   = pos_idx;
    cmd.count = count;
    cmd.value = req_r.value;
  end

  for (genvar g = 0; g < ils_pkg::CAPACITY; g++) begin : g_cell
    logic [ils_pkg::ELEM_BITS-1:0] lo;
    logic [ils_pkg::ELEM_BITS-1:0] hi;
    if (g == 0) begin : g_first
      assign lo = cell_data[g];
    end else begin : g_lo
      assign lo = cell_data[g-1];
    end
    if (g == ils_pkg::CAPACITY - 1) begin : g_last
      assign hi = cell_data[g];
    end else begin : g_hi
      assign hi = cell_data[g+1];
    end
    ils_cell u_cell (
      .clk     (clk),
      .idx     (ils_pkg::IDX_W'(g)),
      .cmd     (cmd),
      .lo_data (lo),
      .hi_data (hi),
      .data    (cell_data[g]),
      .match   (match[g])
    );
  end

  always_comb begin
    found = '0;
    for (int i = ils_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) found = ils_pkg::FOUND_W'(i);
    end
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!rsp_valid || !rsp_stall)) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_r <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          status_r <= status_next;
          rd_r     <= rd_next;
          find_r   <= cmp_next;
          count    <= count_next;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.value_out      <= rd_r;
            rsp.length         <= count;
            rsp.empty_res      <= (count == '0);
            rsp.found_position <= find_r ? found : '0;
            if (find_r) rsp.status <= (|match) ? ils_pkg::ST_OK : ils_pkg::ST_NOT_FOUND;
            else rsp.status <= status_r;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/ils_checker.sv
`timescale 1ns / 1ps
// ils_checker: port-level checks for indexed_list_store_top, bound to the top level
// depends on ils_pkg
module ils_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input ils_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input ils_pkg::rsp_t rsp
);

  localparam logic [ils_pkg::CNT_W-1:0] CAP_CNT = ils_pkg::CNT_W'(ils_pkg::CAPACITY);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.empty_res == (rsp.length == '0)))
    else $error("empty flag disagrees with length");

  a_length: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.length <= CAP_CNT)
    else $error("length above capacity");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while a transaction is in progress");

  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ils_pkg::ST_OK |-> rsp.found_position == '0)
    else $error("found position set on a failed transaction");

endmodule

bind indexed_list_store_top ils_checker u_ils_checker (.*);
